// ===== rtl/ctd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Charstring decrypt and token decode package
// Shared constants, token kinds and the decoder state and result types.
// ----------------------------------------------------------------------------
package ctd_pkg;

  localparam logic [15:0] KEY_MUL    = 16'd52845;
  localparam logic [15:0] KEY_ADD    = 16'd22719;
  localparam logic [15:0] KEY_INIT   = 16'd4330;
  localparam logic [7:0]  ESC_MARK   = 8'd12;
  localparam logic [7:0]  ESC_COUNT  = 8'd51;
  localparam logic [7:0]  CMD_LIMIT  = 8'd32;
  localparam logic [31:0] SMALL_BIAS = 32'd139;
  localparam logic [31:0] TWO_BIAS   = 32'd108;
  localparam logic [7:0]  POS_LEAD   = 8'd247;
  localparam logic [7:0]  NEG_LEAD   = 8'd251;
  localparam logic [7:0]  LONG_LEAD  = 8'd255;
  localparam logic [8:0]  SKIP_RESET = 9'd4;

  localparam logic [2:0] KIND_CMD    = 3'd0;
  localparam logic [2:0] KIND_ESC    = 3'd1;
  localparam logic [2:0] KIND_NUM    = 3'd2;
  localparam logic [2:0] KIND_BADCMD = 3'd3;
  localparam logic [2:0] KIND_BADESC = 3'd4;
  localparam logic [2:0] KIND_TRUNC  = 3'd5;

  typedef struct packed {
    logic [15:0] cipher_key;
    logic [7:0]  skip_left;
    logic        escape_pending;
    logic [2:0]  bytes_pending;
    logic [7:0]  lead_code;
    logic [31:0] number_accumulator;
  } ctd_state_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         token_kind;
    logic [7:0]         op_code;
    logic signed [31:0] number_value;
    logic               end_of_string;
  } ctd_result_t;

endpackage
`default_nettype wire

// ===== rtl/ctd_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Charstring byte decoder step
// Decrypts one byte with the running key, unless skip_count[8] turns decryption
// off, and advances the token decoder, giving the next state and at most one result.
// ----------------------------------------------------------------------------
module ctd_decode (
  input  wire logic [8:0]           skip_count,
  input  wire logic [7:0]           cipher_byte,
  input  wire logic                 first_byte,
  input  wire logic                 last_byte,
  input  wire ctd_pkg::ctd_state_t  state_cur,
  output ctd_pkg::ctd_state_t       state_nxt,
  output ctd_pkg::ctd_result_t      result
);
  import ctd_pkg::*;

  logic        decrypt_off;
  ctd_state_t  st0;
  logic [7:0]  plain;
  logic [15:0] key_sum;
  logic [15:0] key_prod;
  logic [7:0]  skip_dec;
  logic [2:0]  pend_dec;
  logic [31:0] acc_new;
  logic [31:0] two_mag;
  logic [7:0]  lead_off;

  assign decrypt_off = skip_count[8];

  always_comb begin
    st0 = state_cur;
    if (first_byte) begin
      st0.cipher_key         = KEY_INIT;
      st0.skip_left          = decrypt_off ? 8'd0 : skip_count[7:0];
      st0.escape_pending     = 1'b0;
      st0.bytes_pending      = 3'd0;
      st0.lead_code          = 8'd0;
      st0.number_accumulator = 32'd0;
    end
  end

  assign key_sum  = {8'd0, cipher_byte} + st0.cipher_key;
  assign key_prod = key_sum * KEY_MUL + KEY_ADD;
  assign plain    = decrypt_off ? cipher_byte : (cipher_byte ^ st0.cipher_key[15:8]);
  assign skip_dec = st0.skip_left - 8'd1;
  assign pend_dec = st0.bytes_pending - 3'd1;
  assign acc_new  = {st0.number_accumulator[23:0], plain};
  assign lead_off = (st0.lead_code < NEG_LEAD) ? (st0.lead_code - POS_LEAD)
                                               : (st0.lead_code - NEG_LEAD);
  assign two_mag  = TWO_BIAS + {16'd0, lead_off, 8'd0} + {24'd0, acc_new[7:0]};

  always_comb begin
    state_nxt = st0;
    state_nxt.cipher_key = decrypt_off ? st0.cipher_key : key_prod;
    result.valid         = 1'b0;
    result.token_kind    = KIND_CMD;
    result.op_code       = 8'd0;
    result.number_value  = 32'sd0;
    result.end_of_string = last_byte;

    if (st0.skip_left != 8'd0) begin
      state_nxt.skip_left = skip_dec;
      if (last_byte && (skip_dec != 8'd0)) begin
        result.valid      = 1'b1;
        result.token_kind = KIND_TRUNC;
      end
    end else if (st0.escape_pending) begin
      state_nxt.escape_pending = 1'b0;
      result.valid      = 1'b1;
      result.token_kind = (plain < ESC_COUNT) ? KIND_ESC : KIND_BADESC;
      result.op_code    = plain;
    end else if (st0.bytes_pending != 3'd0) begin
      state_nxt.number_accumulator = acc_new;
      state_nxt.bytes_pending      = pend_dec;
      if (pend_dec != 3'd0) begin
        if (last_byte) begin
          state_nxt.bytes_pending      = 3'd0;
          state_nxt.lead_code          = 8'd0;
          state_nxt.number_accumulator = 32'd0;
          result.valid      = 1'b1;
          result.token_kind = KIND_TRUNC;
          result.op_code    = st0.lead_code;
        end
      end else begin
        state_nxt.lead_code          = 8'd0;
        state_nxt.number_accumulator = 32'd0;
        result.valid      = 1'b1;
        result.token_kind = KIND_NUM;
        if (st0.lead_code < NEG_LEAD) begin
          result.number_value = two_mag;
        end else if (st0.lead_code < LONG_LEAD) begin
          result.number_value = 32'd0 - two_mag;
        end else begin
          result.number_value = acc_new;
        end
      end
    end else if (plain == ESC_MARK) begin
      if (last_byte) begin
        result.valid      = 1'b1;
        result.token_kind = KIND_TRUNC;
        result.op_code    = ESC_MARK;
      end else begin
        state_nxt.escape_pending = 1'b1;
      end
    end else if (plain < CMD_LIMIT) begin
      result.valid      = 1'b1;
      result.token_kind = (plain == 8'd0) ? KIND_BADCMD : KIND_CMD;
      result.op_code    = plain;
    end else if (plain < POS_LEAD) begin
      result.valid        = 1'b1;
      result.token_kind   = KIND_NUM;
      result.number_value = {24'd0, plain} - SMALL_BIAS;
    end else if (last_byte) begin
      result.valid      = 1'b1;
      result.token_kind = KIND_TRUNC;
      result.op_code    = plain;
    end else begin
      state_nxt.lead_code          = plain;
      state_nxt.number_accumulator = 32'd0;
      state_nxt.bytes_pending      = (plain == LONG_LEAD) ? 3'd4 : 3'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/charstring_decrypt_token_decoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Charstring decrypt and token decoder unit
// A byte is held in the input register and its result then in the result register.
// Throughput: one byte per cycle unless out_ready stalls; the key update and
// token decode of a byte are one pass of logic between the input and result registers.
// Reset: synchronous, active low; key 4330, skip count 4, decoder cleared.
// ----------------------------------------------------------------------------
module charstring_decrypt_token_decoder_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [7:0]         in_cipher_byte,
  input  wire logic               in_first_byte,
  input  wire logic               in_last_byte,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [2:0]         out_token_kind,
  output      logic [7:0]         out_op_code,
  output      logic signed [31:0] out_number_value,
  output      logic               out_end_of_string,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic signed [8:0]  cfg_skip_count
);
  import ctd_pkg::*;

  logic [8:0]  skip_count_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_first_r;
  logic        s1_last_r;
  ctd_state_t  state_r;
  ctd_state_t  state_nxt;
  ctd_result_t res;
  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [7:0]  out_op_r;
  logic [31:0] out_value_r;
  logic        out_eos_r;
  logic        out_free;
  logic        s1_fire;

  assign out_free  = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign cfg_ready = 1'b1;

  ctd_decode u_decode (
    .skip_count  (skip_count_r),
    .cipher_byte (s1_byte_r),
    .first_byte  (s1_first_r),
    .last_byte   (s1_last_r),
    .state_cur   (state_r),
    .state_nxt   (state_nxt),
    .result      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_count_r <= SKIP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      skip_count_r <= cfg_skip_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_cipher_byte;
      s1_first_r <= in_first_byte;
      s1_last_r  <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.cipher_key         <= KEY_INIT;
      state_r.skip_left          <= 8'd0;
      state_r.escape_pending     <= 1'b0;
      state_r.bytes_pending      <= 3'd0;
      state_r.lead_code          <= 8'd0;
      state_r.number_accumulator <= 32'd0;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && out_free) begin
      out_kind_r  <= res.token_kind;
      out_op_r    <= res.op_code;
      out_value_r <= res.number_value;
      out_eos_r   <= res.end_of_string;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_token_kind    = out_kind_r;
  assign out_op_code       = out_op_r;
  assign out_number_value  = out_value_r;
  assign out_end_of_string = out_eos_r;

endmodule
`default_nettype wire
